### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro names the clock, the active-low reset, a condition and its
// required consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/brtsf_pkg.sv
package brtsf_pkg;

	// One sample of three button bytes, first byte in the lowest bits.
	typedef struct packed {
		logic [7:0] high;
		logic [7:0] mid;
		logic [7:0] low;
	} sample_t;

	localparam int unsigned SAMPLE_W = $bits(sample_t);

	// Host interface modes that select a special remap.
	localparam logic [7:0] MODE_FIRST_REMAP  = 8'd6;
	localparam logic [7:0] MODE_SECOND_REMAP = 8'd7;

endpackage

### rtl/core/brtsf_remap.sv
module brtsf_remap (
	input  brtsf_pkg::sample_t raw,
	input  logic [7:0]         mode,
	output brtsf_pkg::sample_t remapped
);
	import brtsf_pkg::*;

	always_comb begin
		remapped = raw;

		// The middle byte always has bits 0 and 3 exchanged.
		remapped.mid[0] = raw.mid[3];
		remapped.mid[3] = raw.mid[0];

		unique case (mode)
			MODE_FIRST_REMAP: begin
				remapped.high[2] = raw.high[1];
			end
			MODE_SECOND_REMAP: begin
				remapped.high[3] = raw.high[0];
				remapped.high[1] = raw.high[0];
				remapped.low[4]  = raw.high[1] | raw.low[4];
			end
			default: begin
				remapped.high[3] = raw.high[0];
				remapped.high[0] = 1'b0;
			end
		endcase
	end

endmodule

### rtl/core/button_remap_three_sample_filter.sv
// Button remap and stability filter. Each request carries one sample of three
// raw button bytes; the block remaps a few bits according to the host interface
// mode and returns the bitwise AND of the last HISTORY_DEPTH remapped samples,
// so a button reads as pressed only once it has been seen in every one of
// them. The history is cleared at reset, so the first HISTORY_DEPTH - 1
// results after reset are zero. The block takes one request per clock
// cycle while the result side is not held back by m_axis_tready; each result
// passes through the input register and then the result register. Write the mode only
// while no request is in flight.
module button_remap_three_sample_filter #(
	parameter int unsigned HISTORY_DEPTH = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// Mode register write port.
	input  logic                          cfg_wr_en,
	input  logic [7:0]                    cfg_wr_data,   // host_interface_mode

	// Incoming raw samples.
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [7:0] raw_buttons_low, [15:8] raw_buttons_mid, [23:16] raw_buttons_high
	input  logic [brtsf_pkg::SAMPLE_W-1:0] s_axis_tdata,

	// Filtered results.
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [7:0] stable_buttons_low, [15:8] stable_buttons_mid,
	// [23:16] stable_buttons_high
	output logic [brtsf_pkg::SAMPLE_W-1:0] m_axis_tdata
);
	import brtsf_pkg::*;

	// Number of older samples kept besides the one being filtered.
	localparam int unsigned TAPS = HISTORY_DEPTH - 1;

	logic [7:0] mode_q;

	// Input register stage.
	logic    valid_s1;
	sample_t raw_s1;

	// Result register stage.
	logic    valid_s2;
	sample_t result_s2;

	// Previous remapped samples, newest in tap zero.
	sample_t hist_q [TAPS];

	sample_t remapped;
	sample_t filtered;
	logic    ready_s2;
	logic    advance;

	// The mode register is written directly; there is no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// The result register frees up in the same cycle its result is taken, so
	// the input register drains whenever the result side is moving.
	assign ready_s2      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && ready_s2;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			raw_s1 <= sample_t'(s_axis_tdata);
		end
	end

	brtsf_remap u_remap (
		.raw      (raw_s1),
		.mode     (mode_q),
		.remapped (remapped)
	);

	// The AND does not depend on slot order, so the history is kept as a
	// shift line instead of a ring addressed by a write pointer.
	always_comb begin
		filtered = remapped;
		for (int unsigned i = 0; i < TAPS; i++) begin
			filtered = filtered & hist_q[i];
		end
	end

	// The history must read as zero after reset, so it is cleared there.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int unsigned i = 0; i < TAPS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (advance) begin
			hist_q[0] <= remapped;
			for (int unsigned i = 1; i < TAPS; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= filtered;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

endmodule

### rtl/core/brtsf_checker.sv
`include "assert_macros.svh"

module brtsf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [brtsf_pkg::SAMPLE_W-1:0] m_axis_tdata
);

	// A stalled result stays offered and unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// With the result register empty, the input side must never stall.
	`ASSERT_SAME(a_in_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready)

	// A newly raised result must trace back to an accepted request that has passed through the input and result registers.
	`ASSERT_SAME(a_out_from_request, clk, arst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind button_remap_three_sample_filter brtsf_checker u_brtsf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
